### hdl/bde_pkg.sv
// Shared types and constants for the backward difference extrapolator.
// Used by bde_cell, backward_difference_extrapolator_core and the testbench; depends on nothing.
`timescale 1ns / 1ps

package bde_pkg;

   localparam int SAMPLE_W = 32;
   localparam int VALUE_W  = 64;

   // A difference value traveling down the chain of cells.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [VALUE_W-1:0] value;
   } bde_token_type;

   // First entry of a row, reported by the cell that opens that row.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [VALUE_W-1:0] value;
   } bde_term_type;

endpackage

### hdl/bde_cell.sv
// One difference cell: holds the latest entry of one row of the difference table.
// Depends on bde_pkg for the token and term types.
`timescale 1ns / 1ps

module bde_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bde_pkg::bde_token_type tok_in,
   output bde_pkg::bde_token_type tok_out,
   output bde_pkg::bde_term_type  term_out
);

   logic                         row_valid_ff, row_valid_in;
   logic [bde_pkg::VALUE_W-1:0]  held_ff, held_in;
   bde_pkg::bde_token_type       tok_ff, tok_in_next;
   bde_pkg::bde_term_type        term_ff, term_in;

   // A held row passes the difference on; an empty row opens with the entry.
   always_comb begin
      row_valid_in = row_valid_ff;
      held_in      = held_ff;
      tok_in_next  = '{valid: 1'b0, last: tok_in.last, value: tok_in.value - held_ff};
      term_in      = '{valid: 1'b0, last: tok_in.last, value: tok_in.value};
      if (tok_in.valid) begin
         held_in      = tok_in.value;
         // The final sample of a sequence leaves the row empty behind it.
         row_valid_in = !tok_in.last;
         if (row_valid_ff) begin
            tok_in_next.valid = 1'b1;
         end else begin
            term_in.valid = 1'b1;
         end
      end
   end

   // Control bits are reset; the held entry and payloads are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
         term_ff.valid <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         tok_ff.valid <= tok_in_next.valid;
         term_ff.valid <= term_in.valid;
      end
      held_ff       <= held_in;
      tok_ff.last   <= tok_in_next.last;
      tok_ff.value  <= tok_in_next.value;
      term_ff.last  <= term_in.last;
      term_ff.value <= term_in.value;
   end

   assign tok_out  = tok_ff;
   assign term_out = term_ff;

endmodule

### hdl/backward_difference_extrapolator_core.sv
// Top level of the backward difference extrapolator: a chain of difference cells,
// the alternating sum and the result register. Depends on bde_pkg and bde_cell.
`timescale 1ns / 1ps

// Each sample enters a chain of MAX_SAMPLES difference cells and moves down it one
// cell per cycle, so samples that are not marked last are taken one per cycle.
// Once a sample marked last is taken, no further sample is taken until its
// wavefront has reached the row it opens (or left the chain) and the sum has moved
// into the result register; that move waits until the previous result is taken.
// The prediction is the alternating sum of the first entries of all rows, wrapped
// at 64 bits; too_long (rsp_tuser) is set when the sequence had more samples than
// there are cells. After a result, all state is clear for the next sequence.

module backward_difference_extrapolator_core #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] prediction
   output logic        rsp_tuser    // [0] too_long
);

   bde_pkg::bde_token_type      tok  [MAX_SAMPLES+1];
   bde_pkg::bde_term_type       term [MAX_SAMPLES];

   logic                        accept;
   logic                        transfer;
   logic                        done_now;
   logic [bde_pkg::VALUE_W-1:0] even_terms, odd_terms;

   logic                        drain_ff, drain_in;
   logic                        done_ff, done_in;
   logic                        overflow_ff, overflow_in;
   logic [bde_pkg::VALUE_W-1:0] sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bde_pkg::VALUE_W-1:0] rsp_data_ff;
   logic                        rsp_user_ff;

   // Input transaction enters the head of the chain, sign extended.
   assign req_tready = !drain_ff;
   assign accept     = req_tvalid && req_tready;
   assign tok[0]     = '{valid: accept, last: req_tlast,
                         value: {{(bde_pkg::VALUE_W-bde_pkg::SAMPLE_W){req_tdata[31]}},
                                 req_tdata}};

   // The chain of difference cells.
   for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
      bde_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok[k]),
         .tok_out  (tok[k+1]),
         .term_out (term[k])
      );
   end

   // Within one sequence rows open one at a time, so at most one term is valid.
   always_comb begin
      even_terms = '0;
      odd_terms  = '0;
      done_now   = tok[MAX_SAMPLES].valid && tok[MAX_SAMPLES].last;
      for (int k = 0; k < MAX_SAMPLES; k++) begin
         if (term[k].valid) begin
            if (k % 2 == 1) begin
               odd_terms = odd_terms | term[k].value;
            end else begin
               even_terms = even_terms | term[k].value;
            end
            if (term[k].last) begin
               done_now = 1'b1;
            end
         end
      end
   end

   // Sequence control, alternating sum and overflow flag.
   assign transfer = done_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      drain_in    = drain_ff;
      done_in     = done_ff;
      sum_in      = sum_ff + even_terms - odd_terms;
      overflow_in = overflow_ff || tok[MAX_SAMPLES].valid;
      if (accept && req_tlast) begin
         drain_in = 1'b1;
      end
      if (done_now) begin
         done_in = 1'b1;
      end
      if (transfer) begin
         drain_in    = 1'b0;
         done_in     = 1'b0;
         sum_in      = '0;
         overflow_in = 1'b0;
      end
   end

   // Result register parts the chain from the output side.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         done_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         done_ff      <= done_in;
         overflow_ff  <= overflow_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (transfer) begin
         rsp_data_ff <= sum_ff;
         rsp_user_ff <= overflow_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### test/tb.sv
// Self-checking testbench for backward_difference_extrapolator_core.
// Depends on bde_pkg and the core; drives sample streams and checks every prediction.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_SAMPLES    = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = MAX_SAMPLES + 8;
   localparam int SAMPLE_W       = bde_pkg::SAMPLE_W;
   localparam int VALUE_W        = bde_pkg::VALUE_W;

   // Kinds of sequence content that the stimulus produces.
   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_POLYNOMIAL
   } content_kind_type;

   // One expected result: the extrapolated value and the too-long flag.
   typedef struct {
      logic [VALUE_W-1:0] prediction;
      logic               too_long;
   } prediction_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;   // [31:0] sample
   logic                req_tlast  = 1'b0; // is_last
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [VALUE_W-1:0]  rsp_tdata;         // [63:0] prediction
   logic                rsp_tuser;         // [0] too_long

   // Own copy of the difference table, mirrored on every accepted sample.
   logic [VALUE_W-1:0] diagonal_entries [MAX_SAMPLES];
   int                 rows_open;
   logic [VALUE_W-1:0] running_prediction;
   logic               sequence_overflowed;

   prediction_type expected_predictions [$];
   int             failures          = 0;
   int             samples_sent      = 0;
   int             sender_idle_pct   = 0;
   int             receiver_idle_pct = 0;
   int             stall_cycles      = 0;

   backward_difference_extrapolator_core #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Return the table to its empty state, as the block does after a last sample.
   task automatic clear_difference_table();
      for (int k = 0; k < MAX_SAMPLES; k++) begin
         diagonal_entries[k] = '0;
      end
      rows_open           = 0;
      running_prediction  = '0;
      sequence_overflowed = 1'b0;
   endtask

   // Push one sample down the diagonal and, on the last one, queue the prediction.
   task automatic advance_difference_table(input logic [SAMPLE_W-1:0] sample_value,
                                           input logic last_sample);
      logic [VALUE_W-1:0] entry;
      logic [VALUE_W-1:0] previous;
      prediction_type     outcome;
      int                 k;
      entry = {{(VALUE_W - SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
      for (k = 0; k < rows_open; k++) begin
         previous            = diagonal_entries[k];
         diagonal_entries[k] = entry;
         entry               = entry - previous;
      end
      // A new row opens only while there is a cell left for it.
      if (rows_open < MAX_SAMPLES) begin
         diagonal_entries[rows_open] = entry;
         if (rows_open % 2 == 1) begin
            running_prediction = running_prediction - entry;
         end else begin
            running_prediction = running_prediction + entry;
         end
         rows_open = rows_open + 1;
      end else begin
         sequence_overflowed = 1'b1;
      end
      if (last_sample) begin
         outcome.prediction = running_prediction;
         outcome.too_long   = sequence_overflowed;
         expected_predictions.push_back(outcome);
         clear_difference_table();
      end
   endtask

   // Offer one sample, idling at random first, and wait for the transaction.
   // The valid stays high afterwards so back-to-back samples need no gap.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample_value,
                              input logic last_sample);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample_value;
      req_tlast  <= last_sample;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      advance_difference_table(sample_value, last_sample);
      samples_sent++;
   endtask

   // Stop offering samples until every queued prediction has been checked.
   task automatic wait_for_predictions();
      if (expected_predictions.size() != 0) begin
         req_tvalid <= 1'b0;
         while (expected_predictions.size() != 0) begin
            @(posedge clock);
         end
      end
   endtask

   // A sample biased toward the extremes and small magnitudes.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int choice;
      choice = $urandom_range(9);
      case (choice)
         0: begin
            return 32'h7FFF_FFFF;
         end
         1: begin
            return 32'h8000_0000;
         end
         2: begin
            return $urandom_range(16) - 8;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Mostly short sequences, some up to the cell count, a few past it.
   function automatic int pick_length();
      int choice;
      choice = $urandom_range(99);
      if (choice < 80) begin
         return $urandom_range(8, 1);
      end else if (choice < 94) begin
         return $urandom_range(MAX_SAMPLES, 9);
      end else begin
         return $urandom_range(MAX_SAMPLES + 12, MAX_SAMPLES + 1);
      end
   endfunction

   // Send a whole sequence; polynomial content lets the difference rows reach zero.
   task automatic send_sequence(input int length, input content_kind_type content);
      int                  c0;
      int                  c1;
      int                  c2;
      int                  c3;
      logic [SAMPLE_W-1:0] sample_value;
      c0 = $urandom;
      c1 = $urandom_range(200) - 100;
      c2 = $urandom_range(40) - 20;
      c3 = $urandom_range(6) - 3;
      for (int i = 0; i < length; i++) begin
         if (content == CONTENT_POLYNOMIAL) begin
            sample_value = c0 + c1 * i + c2 * i * i + c3 * i * i * i;
         end else begin
            sample_value = pick_sample();
         end
         send_sample(sample_value, i == length - 1);
      end
   endtask

   // Single samples at the extremes, extreme pairs and short polynomial runs.
   task automatic test_directed();
      sender_idle_pct   = 26;
      receiver_idle_pct = 48;
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_sample(3 * i, i == 5);
      end
      for (int i = 0; i < 6; i++) begin
         send_sample(10 + 2 * i + i * i * i / 1, i == 5);
      end
      wait_for_predictions();
   endtask

   // Sequences that fill every cell exactly, and ones that run past the cells.
   task automatic test_sequence_length();
      sender_idle_pct   = 26;
      receiver_idle_pct = 48;
      send_sequence(MAX_SAMPLES, CONTENT_RANDOM);
      send_sequence(MAX_SAMPLES + 1, CONTENT_RANDOM);
      for (int i = 0; i < MAX_SAMPLES + 8; i++) begin
         send_sample(i % 2 == 0 ? 32'h7FFF_FFFF : 32'h8000_0000, i == MAX_SAMPLES + 7);
      end
      send_sequence(MAX_SAMPLES, CONTENT_POLYNOMIAL);
      wait_for_predictions();
   endtask

   // The sender holds off until each prediction has been taken.
   task automatic test_pause_until_drained();
      sender_idle_pct   = 26;
      receiver_idle_pct = 48;
      for (int n = 0; n < 6; n++) begin
         send_sequence(pick_length(), n % 2 == 0 ? CONTENT_RANDOM : CONTENT_POLYNOMIAL);
         wait_for_predictions();
      end
   endtask

   // Random sequences under one idling pattern, with an occasional drain.
   task automatic run_random_phase(input int send_pct, input int receive_pct,
                                   input int sample_budget);
      int first_sample;
      first_sample      = samples_sent;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = receive_pct;
      while (samples_sent - first_sample < sample_budget) begin
         send_sequence(pick_length(),
                       $urandom_range(1) == 0 ? CONTENT_RANDOM : CONTENT_POLYNOMIAL);
         if ($urandom_range(19) == 0) begin
            wait_for_predictions();
         end
      end
      wait_for_predictions();
   endtask

   task automatic test_random_sequences();
      run_random_phase(26, 48, 320);
      run_random_phase(48, 26, 320);
      run_random_phase(0, 0, 320);
   endtask

   // Check each prediction transaction against the oldest expectation.
   always @(posedge clock) begin
      prediction_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_predictions.size() == 0) begin
            $display("%0t: unexpected prediction %h too_long %b", $time, rsp_tdata,
                     rsp_tuser);
            failures++;
         end else begin
            wanted = expected_predictions.pop_front();
            if (rsp_tdata !== wanted.prediction) begin
               $display("%0t: prediction expected %h actual %h", $time,
                        wanted.prediction, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== wanted.too_long) begin
               $display("%0t: too_long expected %b actual %b", $time, wanted.too_long,
                        rsp_tuser);
               failures++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // End the run if no transaction moves on either side for too long.
   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Test sequence.
   initial begin
      clear_difference_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_sequence_length();
      test_pause_until_drained();
      test_random_sequences();
      wait_for_predictions();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_predictions.size() != 0) begin
         $display("%0t: %0d predictions never arrived", $time,
                  expected_predictions.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
